@@ design/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Field widths of the request and result items.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // Character codes and the attribute after reset.
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

@@ design/text_console_writer_core.sv @@
// Text console writer: a character screen of ROWS x COLUMNS 16-bit cells
// (attribute in the high byte, character in the low byte) plus a cursor.
// Requests arrive on the slave stream; func travels in tuser, the character
// and the read position in tdata. Every request gives exactly one result on
// the master stream: the cell read (zero for other functions), the cursor
// after the request and a flag that the screen scrolled.
// The user must write the attribute register by i_cfg_wr_en / i_cfg_wr_data
// only while the block is idle; the block itself does not enforce it. Reset
// sets the attribute to 0x0F and homes the cursor. The screen store is a
// single memory with one write and one registered read port. A put without
// scroll and a read are accepted, then the done state loads the output
// register. A clear sweeps the store one cell a cycle. A put that scrolls
// copies rows one cell a cycle through the read port and then blanks the
// bottom row. The store is undefined after reset until the first clear. The
// output register holds a result until the receiver takes it; while it is
// held the next request is still accepted, and its result waits in the done
// state until the output register is free.
`default_nettype none

module text_console_writer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Attribute register write.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata: char_code[7:0], read_row[12:8], read_column[19:13], zero fill.
    input  wire logic [23:0] i_s_tdata,
    // tuser: func[1:0].
    input  wire logic [1:0]  i_s_tuser,
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata: cell_data[15:0], cursor_column[22:16], cursor_row[27:23],
    // scrolled[28], zero fill.
    output logic [31:0]      o_m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_PUT_WRITE,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state                          r_state;
    logic [tcw_pkg::ATTR_W-1:0]      r_attr;
    logic [tcw_pkg::COL_W-1:0]       r_cx;
    logic [tcw_pkg::ROW_W-1:0]       r_cy;
    logic [tcw_pkg::CHAR_W-1:0]      r_char;
    logic [tcw_pkg::ADDR_W-1:0]      r_idx;
    logic                            r_cp_valid;
    logic [tcw_pkg::ADDR_W-1:0]      r_cp_addr;
    logic                            r_rd_ok;
    logic                            r_scrolled;
    logic                            r_out_valid;
    logic [31:0]                     r_out_data;

    // Screen store.
    logic [tcw_pkg::CELL_W-1:0]      r_screen [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0]      r_rd_data;

    logic                            mem_we;
    logic [tcw_pkg::ADDR_W-1:0]      mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [tcw_pkg::ADDR_W-1:0]      mem_raddr;

    // Request fields.
    logic                            accept;
    tcw_pkg::t_func                  in_func;
    logic [tcw_pkg::CHAR_W-1:0]      in_char;
    logic [tcw_pkg::ROW_W-1:0]       in_row;
    logic [tcw_pkg::COL_W-1:0]       in_col;

    // Cursor update of a put.
    logic                            put_wrap;
    logic [tcw_pkg::ROW_W-1:0]       put_y_wrapped;
    logic                            put_scroll;
    logic [tcw_pkg::ROW_W-1:0]       put_y;
    logic [tcw_pkg::COL_W-1:0]       put_x;
    logic                            put_printable;
    logic                            rd_in_range;
    logic                            out_free;
    logic [tcw_pkg::CELL_W-1:0]      blank_cell;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_func    = tcw_pkg::t_func'(i_s_tuser);
    assign in_char    = i_s_tdata[7:0];
    assign in_row     = i_s_tdata[12:8];
    assign in_col     = i_s_tdata[19:13];
    assign blank_cell = {r_attr, tcw_pkg::CHAR_BLANK};
    assign out_free   = !r_out_valid || i_m_tready;

    // Wrap on newline or pending wrap, then scroll from the last row.
    always_comb begin
        put_wrap      = (in_char == tcw_pkg::CHAR_NEWLINE)
                        || (r_cx >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
        put_x         = put_wrap ? '0 : r_cx;
        put_y_wrapped = r_cy + tcw_pkg::ROW_W'(put_wrap);
        put_scroll    = (put_y_wrapped >= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        put_y         = put_scroll ? put_y_wrapped - 1'b1 : put_y_wrapped;
        put_printable = (in_char != tcw_pkg::CHAR_NUL)
                        && (in_char != tcw_pkg::CHAR_NEWLINE);
        rd_in_range   = (in_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                        && (in_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    end

    // Memory port control per state.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = blank_cell;
        mem_re    = 1'b0;
        mem_raddr = tcw_pkg::cell_addr(in_row, in_col);
        case (r_state)
            ST_IDLE: begin
                if (accept && in_func == tcw_pkg::FUNC_PUT && !put_scroll && put_printable) begin
                    mem_we    = 1'b1;
                    mem_waddr = tcw_pkg::cell_addr(put_y, put_x);
                    mem_wdata = {r_attr, in_char};
                end
                mem_re = accept && in_func == tcw_pkg::FUNC_READ && rd_in_range;
            end
            ST_SCROLL_COPY: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                mem_we    = r_cp_valid;
                mem_waddr = r_cp_addr;
                mem_wdata = r_rd_data;
            end
            ST_SCROLL_FILL: begin
                // Drain the last copied cell before blanking the bottom row.
                mem_we    = 1'b1;
                mem_waddr = r_cp_valid ? r_cp_addr : r_idx;
                mem_wdata = r_cp_valid ? r_rd_data : blank_cell;
            end
            ST_PUT_WRITE: begin
                mem_we    = (r_char != tcw_pkg::CHAR_NUL)
                            && (r_char != tcw_pkg::CHAR_NEWLINE);
                mem_waddr = tcw_pkg::cell_addr(r_cy, r_cx);
                mem_wdata = {r_attr, r_char};
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Screen store write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_screen[mem_raddr];
        end
    end

    // Sequencer, cursor and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            // The done state reloads the output register itself.
            if (r_out_valid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_scrolled <= 1'b0;
                        r_rd_ok    <= 1'b0;
                        r_char     <= in_char;
                        r_idx      <= '0;
                        case (in_func)
                            tcw_pkg::FUNC_PUT: begin
                                r_cy <= put_y;
                                if (put_scroll) begin
                                    r_cx       <= put_x;
                                    r_scrolled <= 1'b1;
                                    r_cp_valid <= 1'b0;
                                    r_state    <= ST_SCROLL_COPY;
                                end else begin
                                    r_cx    <= put_x + tcw_pkg::COL_W'(put_printable);
                                    r_state <= ST_DONE;
                                end
                            end
                            tcw_pkg::FUNC_CLEAR: begin
                                r_cx    <= '0;
                                r_cy    <= '0;
                                r_state <= ST_CLEAR;
                            end
                            tcw_pkg::FUNC_READ: begin
                                r_rd_ok <= rd_in_range;
                                r_state <= ST_DONE;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCROLL_COPY: begin
                    // Read cell idx + COLUMNS now, write it to idx next cycle.
                    r_cp_valid <= 1'b1;
                    r_cp_addr  <= r_idx;
                    if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT - 1)) begin
                        r_idx   <= tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT);
                        r_state <= ST_SCROLL_FILL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SCROLL_FILL: begin
                    if (r_cp_valid) begin
                        r_cp_valid <= 1'b0;
                    end else if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
                        r_state <= ST_PUT_WRITE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_PUT_WRITE: begin
                    if ((r_char != tcw_pkg::CHAR_NUL) && (r_char != tcw_pkg::CHAR_NEWLINE)) begin
                        r_cx <= r_cx + 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_CLEAR: begin
                    if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DONE: begin
                    // Load the result once the output register is free.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b000, r_scrolled, r_cy, r_cx,
                                        r_rd_ok ? r_rd_data : '0};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTH
    // The cursor row never rests on the last row; a put there scrolls.
    a_row_below_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cy < tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
        else $error("cursor row reached the last row");

    // The cursor column never passes the pending-wrap position.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cx <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
        else $error("cursor column beyond wrap position");

    // A pending copy write only exists during the scroll sweep.
    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == ST_SCROLL_COPY || r_state == ST_SCROLL_FILL))
        else $error("copy write pending outside scroll");

    // A scrolled result leaves the cursor on the row above the last.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[28]) |->
            (o_m_tdata[27:23] == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 2)))
        else $error("scrolled result with wrong cursor row");

    // No request is taken while a scroll or clear sweep runs.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL_COPY || r_state == ST_CLEAR) |=> !$past(accept))
        else $error("request accepted during a sweep");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_text_console_writer_core.sv @@
`timescale 1ns / 1ps

module tb_text_console_writer_core;

    // A result beat as packed on the master tdata, lowest field last.
    typedef struct packed {
        logic                       scrolled;
        logic [tcw_pkg::ROW_W-1:0]  cursor_row;
        logic [tcw_pkg::COL_W-1:0]  cursor_col;
        logic [tcw_pkg::CELL_W-1:0] cell_data;
    } t_console_result;

    // One request of the directed table. When has_fixed is set, the result
    // is the one typed in the row; otherwise the predictor supplies it.
    typedef struct packed {
        tcw_pkg::t_func             func;
        logic [tcw_pkg::CHAR_W-1:0] char_code;
        logic [tcw_pkg::ROW_W-1:0]  read_row;
        logic [tcw_pkg::COL_W-1:0]  read_col;
        logic                       has_fixed;
        t_console_result            fixed;
    } t_directed_row;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 12;
    localparam int STALL_LIMIT = 10000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 222;

    // func, char, row, column, fixed, {scrolled, cursor row, cursor column, cell data}
    localparam t_directed_row DIRECTED_ROWS [0:21] = '{
        // A put before the first clear writes only cell zero.
        '{tcw_pkg::FUNC_PUT,   8'h41, 5'd0,  7'd0,   1'b1, '{1'b0, 5'd0, 7'd1, 16'h0000}},
        '{tcw_pkg::FUNC_CLEAR, 8'h00, 5'd0,  7'd0,   1'b1, '{1'b0, 5'd0, 7'd0, 16'h0000}},
        // Corners of a freshly cleared screen hold blanks in the reset attribute.
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd0,  7'd0,   1'b1, '{1'b0, 5'd0, 7'd0, 16'h0F20}},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd24, 7'd79,  1'b1, '{1'b0, 5'd0, 7'd0, 16'h0F20}},
        // Reads outside the screen return zero.
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd25, 7'd0,   1'b1, '{1'b0, 5'd0, 7'd0, 16'h0000}},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd0,  7'd80,  1'b1, '{1'b0, 5'd0, 7'd0, 16'h0000}},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd31, 7'd127, 1'b1, '{1'b0, 5'd0, 7'd0, 16'h0000}},
        // The unused function changes nothing.
        '{tcw_pkg::FUNC_NOP,   8'hFF, 5'd31, 7'd127, 1'b1, '{1'b0, 5'd0, 7'd0, 16'h0000}},
        '{tcw_pkg::FUNC_PUT,   8'hFF, 5'd31, 7'd127, 1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h00, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h80, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h0A, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h7F, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_READ,  8'hFF, 5'd0,  7'd1,   1'b0, '0},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd1,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h0A, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h0A, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd0,  7'd2,   1'b0, '0},
        '{tcw_pkg::FUNC_NOP,   8'h00, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_PUT,   8'h55, 5'd0,  7'd0,   1'b0, '0},
        '{tcw_pkg::FUNC_READ,  8'h00, 5'd3,  7'd0,   1'b0, '0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_s_tvalid    = 1'b0;
    logic        o_s_tready;
    // tdata: char_code[7:0], read_row[12:8], read_column[19:13], zero fill.
    logic [23:0] i_s_tdata     = 24'h000000;
    // tuser: func[1:0].
    logic [1:0]  i_s_tuser     = 2'b00;
    logic        o_m_tvalid;
    logic        i_m_tready    = 1'b0;
    // tdata: cell_data[15:0], cursor_column[22:16], cursor_row[27:23],
    // scrolled[28], zero fill.
    logic [31:0] o_m_tdata;

    // Shadow of the screen, the cursor and the attribute register.
    logic [tcw_pkg::CELL_W-1:0] screen_shadow [0:tcw_pkg::CELL_COUNT-1];
    int                         shadow_col;
    int                         shadow_row;
    logic [tcw_pkg::ATTR_W-1:0] shadow_attr;

    t_console_result   pending_results [$];
    int                error_count = 0;
    logic              pacing_on   = 1'b0;

    text_console_writer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one request to the shadow screen and return the result it gives.
    function automatic t_console_result predict_console_result(
            input tcw_pkg::t_func f, input logic [tcw_pkg::CHAR_W-1:0] ch,
            input logic [tcw_pkg::ROW_W-1:0] r, input logic [tcw_pkg::COL_W-1:0] c);
        t_console_result res;
        int              k;
        res = '0;
        case (f)
            tcw_pkg::FUNC_PUT: begin
                // Newline or a pending wrap moves to the next line first.
                if (ch == tcw_pkg::CHAR_NEWLINE || shadow_col >= tcw_pkg::COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // Reaching the last row scrolls everything up by one row.
                if (shadow_row >= tcw_pkg::ROWS - 1) begin
                    for (k = 0; k < tcw_pkg::COPY_COUNT; k++)
                        screen_shadow[k] = screen_shadow[k + tcw_pkg::COLUMNS];
                    for (k = tcw_pkg::COPY_COUNT; k < tcw_pkg::CELL_COUNT; k++)
                        screen_shadow[k] = {shadow_attr, tcw_pkg::CHAR_BLANK};
                    res.scrolled = 1'b1;
                    shadow_row--;
                end
                if (ch != tcw_pkg::CHAR_NUL && ch != tcw_pkg::CHAR_NEWLINE) begin
                    if (shadow_col < tcw_pkg::COLUMNS)
                        screen_shadow[shadow_row * tcw_pkg::COLUMNS + shadow_col] =
                            {shadow_attr, ch};
                    shadow_col++;
                end
            end
            tcw_pkg::FUNC_CLEAR: begin
                for (k = 0; k < tcw_pkg::CELL_COUNT; k++)
                    screen_shadow[k] = {shadow_attr, tcw_pkg::CHAR_BLANK};
                shadow_col = 0;
                shadow_row = 0;
            end
            tcw_pkg::FUNC_READ: begin
                if (r < tcw_pkg::ROWS && c < tcw_pkg::COLUMNS)
                    res.cell_data = screen_shadow[int'(r) * tcw_pkg::COLUMNS + int'(c)];
            end
            default: begin
            end
        endcase
        res.cursor_col = tcw_pkg::COL_W'(shadow_col);
        res.cursor_row = tcw_pkg::ROW_W'(shadow_row);
        return res;
    endfunction

    // Present one request, wait for it to be taken, then queue its result.
    task automatic send_request(input tcw_pkg::t_func f,
            input logic [tcw_pkg::CHAR_W-1:0] ch,
            input logic [tcw_pkg::ROW_W-1:0] r, input logic [tcw_pkg::COL_W-1:0] c,
            input logic has_fixed, input t_console_result fixed);
        t_console_result predicted;
        int              gap;
        if (pacing_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {4'b0000, c, r, ch};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_console_result(f, ch, r, c);
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    // Let the block go idle, then write the attribute register.
    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        shadow_attr = value;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
            input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Receiver pacing: random stall bursts while pacing is on.
    initial begin : sink_pacing
        int gap;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pacing_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 4);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_console_result got;
        t_console_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[28:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("cell_data", want.cell_data, got.cell_data);
                check_field("cursor_column", 16'(want.cursor_col), 16'(got.cursor_col));
                check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
                check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
            end
        end
    end

    // Ends the run when no request or result moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL text_console_writer_core");
        $finish;
    end

    // Main stimulus: directed table, then phases of random requests.
    initial begin : stimulus
        int                         newline_pct [0:PHASES-1];
        int                         p;
        int                         n;
        int                         sel;
        tcw_pkg::t_func             f;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [tcw_pkg::ROW_W-1:0]  r;
        logic [tcw_pkg::COL_W-1:0]  c;
        logic [tcw_pkg::ATTR_W-1:0] attr;
        newline_pct = '{25, 1, 10, 2, 30, 5};
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = tcw_pkg::ATTR_RESET;
        for (n = 0; n < tcw_pkg::CELL_COUNT; n++)
            screen_shadow[n] = '0;

        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests run with the attribute left at its reset value.
        for (n = 0; n < $size(DIRECTED_ROWS); n++)
            send_request(DIRECTED_ROWS[n].func, DIRECTED_ROWS[n].char_code,
                         DIRECTED_ROWS[n].read_row, DIRECTED_ROWS[n].read_col,
                         DIRECTED_ROWS[n].has_fixed, DIRECTED_ROWS[n].fixed);

        for (p = 0; p < PHASES; p++) begin
            // Attribute extremes first, then random values and the reset value.
            case (p)
                0:       attr = 8'hFF;
                1:       attr = 8'h00;
                3:       attr = tcw_pkg::ATTR_RESET;
                default: attr = 8'($urandom_range(0, 255));
            endcase
            write_attribute(attr);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Pacing switches in stretches; the last phase runs flat out.
                if (n % 40 == 0)
                    pacing_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                sel = $urandom_range(0, 999);
                ch  = 8'($urandom_range(0, 255));
                r   = 5'($urandom_range(0, 31));
                c   = 7'($urandom_range(0, 127));
                if (sel < 5) begin
                    f = tcw_pkg::FUNC_CLEAR;
                end else if (sel < 35) begin
                    f = tcw_pkg::FUNC_NOP;
                end else if (sel < 300) begin
                    f = tcw_pkg::FUNC_READ;
                    // Most reads land on the screen, often on the cursor line.
                    if ($urandom_range(0, 4) != 0) begin
                        r = ($urandom_range(0, 1) == 0)
                            ? tcw_pkg::ROW_W'(shadow_row)
                            : 5'($urandom_range(0, tcw_pkg::ROWS - 1));
                        c = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
                    end
                end else begin
                    f = tcw_pkg::FUNC_PUT;
                    if ($urandom_range(0, 99) < newline_pct[p])
                        ch = tcw_pkg::CHAR_NEWLINE;
                    else if ($urandom_range(0, 49) == 0)
                        ch = tcw_pkg::CHAR_NUL;
                end
                send_request(f, ch, r, c, 1'b0, '0);
            end
        end

        // Drain the remaining results, then allow for any stray one.
        i_s_tvalid <= 1'b0;
        pacing_on = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS text_console_writer_core");
        else
            $display("FAIL text_console_writer_core");
        $finish;
    end

endmodule
